// ----- rtl/modbus_rtu_write_frame_builder_unit_macros.svh -----
// assertion macros used by the back part of the frame builder rtl
`ifndef MODBUS_RTU_WRITE_FRAME_BUILDER_UNIT_MACROS_SVH
`define MODBUS_RTU_WRITE_FRAME_BUILDER_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MRWFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define MRWFB_ASSERT_NEXT(label, ante, cons, msg) \
  `MRWFB_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/mrwfb_pkg.sv -----
// types, constants and sequencer codes of the modbus rtu frame builder
package mrwfb_pkg;

  localparam logic [7:0]  FUNC_CODE = 8'h46;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // default depth of the command queue between front and back
  localparam int QDEPTH_DEF = 4;

  // byte sequencer codes, in wire order
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SADDR  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FUNC   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RA_HI  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RA_LO  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RC_HI  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RC_LO  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BCNT   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DATA   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd9;

  typedef struct packed {
    logic        start_frame;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [15:0] reg_count;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     emit_data;
    logic     emit_crc;
  } cmd_t;

endpackage

// ----- rtl/mrwfb_cmdq.sv -----
// small register queue of classified commands between front and back
module mrwfb_cmdq #(
  parameter int DEPTH = mrwfb_pkg::QDEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrwfb_pkg::cmd_t din,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output mrwfb_pkg::cmd_t dout
);
  import mrwfb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mrwfb_front.sv -----
// front part: accepts input beats, tracks the open frame, classifies work
module mrwfb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  mrwfb_pkg::in_item_t in_item,
  output logic                q_push,
  output mrwfb_pkg::cmd_t     q_cmd
);
  import mrwfb_pkg::*;

  logic [7:0] bytes_left_r;
  logic       frame_open_r;
  logic [7:0] bl_after;
  logic       emit_data, emit_crc, keep;

  // classify the beat against the frame state
  always_comb begin
    emit_data = 1'b0;
    bl_after  = bytes_left_r;
    keep      = 1'b0;
    if (in_item.start_frame) begin
      emit_data = (in_item.byte_count != 8'd0);
      bl_after  = in_item.byte_count - {7'd0, emit_data};
      keep      = 1'b1;
    end else if (frame_open_r) begin
      emit_data = (bytes_left_r != 8'd0);
      bl_after  = bytes_left_r - {7'd0, emit_data};
      keep      = 1'b1;
    end
    emit_crc = (bl_after == 8'd0);
  end

  // data beats with no frame open are dropped here
  assign q_push          = push && !full && keep;
  assign q_cmd.item      = in_item;
  assign q_cmd.emit_data = emit_data;
  assign q_cmd.emit_crc  = emit_crc;

  // frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      frame_open_r <= 1'b0;
    end else if (q_push) begin
      bytes_left_r <= bl_after;
      frame_open_r <= !emit_crc;
    end
  end

endmodule

// ----- rtl/mrwfb_back.sv -----
// back part: serializes commands into frame bytes and keeps the running crc
`include "modbus_rtu_write_frame_builder_unit_macros.svh"

module mrwfb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  mrwfb_pkg::cmd_t      head,
  output logic                 head_pop,
  output logic                 empty,
  input  logic                 pop,
  output mrwfb_pkg::out_item_t out_item
);
  import mrwfb_pkg::*;

  // one byte into crc-16/modbus, eight shift steps
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [15:0]       crc_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [STEP_W-1:0] first_step, cur_step, step_nxt;
  logic              last;
  logic [7:0]        byte_sel;
  logic [15:0]       crc_base, crc_nxt;
  logic              out_adv, fire;

  // step of the head command this cycle
  always_comb begin
    if (head.item.start_frame) begin
      first_step = STEP_SADDR;
    end else if (head.emit_data) begin
      first_step = STEP_DATA;
    end else begin
      first_step = STEP_CRC_LO;
    end
    cur_step = busy_r ? step_r : first_step;
  end

  // next step and end of command
  always_comb begin
    step_nxt = cur_step;
    last     = 1'b0;
    case (cur_step)
      STEP_SADDR, STEP_FUNC, STEP_RA_HI, STEP_RA_LO, STEP_RC_HI, STEP_RC_LO: begin
        step_nxt = cur_step + 1'b1;
      end
      STEP_BCNT: begin
        if (head.emit_data) begin
          step_nxt = STEP_DATA;
        end else if (head.emit_crc) begin
          step_nxt = STEP_CRC_LO;
        end else begin
          last = 1'b1;
        end
      end
      STEP_DATA: begin
        if (head.emit_crc) begin
          step_nxt = STEP_CRC_LO;
        end else begin
          last = 1'b1;
        end
      end
      STEP_CRC_LO: begin
        step_nxt = STEP_CRC_HI;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // byte on the wire for this step
  always_comb begin
    crc_base = (cur_step == STEP_SADDR) ? CRC_INIT : crc_r;
    case (cur_step)
      STEP_SADDR:  byte_sel = head.item.slave_addr;
      STEP_FUNC:   byte_sel = FUNC_CODE;
      STEP_RA_HI:  byte_sel = head.item.reg_addr[15:8];
      STEP_RA_LO:  byte_sel = head.item.reg_addr[7:0];
      STEP_RC_HI:  byte_sel = head.item.reg_count[15:8];
      STEP_RC_LO:  byte_sel = head.item.reg_count[7:0];
      STEP_BCNT:   byte_sel = head.item.byte_count;
      STEP_DATA:   byte_sel = head.item.data_byte;
      STEP_CRC_LO: byte_sel = crc_r[7:0];
      default:     byte_sel = crc_r[15:8];
    endcase
    crc_nxt = crc_fold(crc_base, byte_sel);
  end

  assign out_adv  = !out_valid_r || pop;
  assign fire     = head_valid && out_adv;
  assign head_pop = fire && last;
  assign empty    = !out_valid_r;
  assign out_item = out_data_r;

  // sequencer and crc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_SADDR;
      crc_r  <= CRC_INIT;
    end else if (fire) begin
      busy_r <= !last;
      step_r <= step_nxt;
      if (cur_step == STEP_CRC_HI) begin
        crc_r <= CRC_INIT;
      end else if (cur_step <= STEP_DATA) begin
        crc_r <= crc_nxt;
      end
    end
  end

  // output register, one result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.tx_byte   <= byte_sel;
      out_data_r.frame_end <= (cur_step == STEP_CRC_HI);
      out_data_r.run_last  <= last;
    end
  end

  `MRWFB_ASSERT(a_end_is_last, out_valid_r && out_data_r.frame_end |-> out_data_r.run_last, "frame end not last of beat")
  `MRWFB_ASSERT(a_busy_has_cmd, busy_r |-> head_valid, "sequencer busy with empty queue")
  `MRWFB_ASSERT_NEXT(a_crc_reinit, fire && cur_step == STEP_CRC_HI, crc_r == CRC_INIT, "crc not reinitialized after close")

endmodule

// ----- rtl/modbus_rtu_write_frame_builder_unit.sv -----
// accepted beats pass the command queue (QDEPTH entries) to the byte sequencer, which fills
// the result register at one byte per cycle while it is empty or popped; a start beat gives
// the header, a data byte and/or the crc, a data beat its byte and, at frame end, the crc;
// beats are taken every cycle while the queue has room; a full result register stalls only
// the sequencer; reset: synchronous active low rst_n empties queue and result register,
// closes any frame and sets the crc to 0xFFFF
module modbus_rtu_write_frame_builder_unit #(
  parameter int QDEPTH = mrwfb_pkg::QDEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  mrwfb_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output mrwfb_pkg::out_item_t out_item
);
  import mrwfb_pkg::*;

  logic q_push, q_valid, q_pop;
  cmd_t q_cmd, q_head;

  // front: accept and classify
  mrwfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // command queue between the two sides
  mrwfb_cmdq #(
    .DEPTH (QDEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd),
    .full  (full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_head)
  );

  // back: byte sequencer, crc and result register
  mrwfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

// ----- dv/frame_builder_checker.sv -----
// checker that predicts and compares the result bytes of the modbus rtu frame builder
module frame_builder_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  mrwfb_pkg::in_item_t  in_item,
  input  logic                 empty,
  input  logic                 pop,
  input  mrwfb_pkg::out_item_t out_item,
  input  logic                 end_check,
  output int                   err_count,
  output int                   pending,
  output int                   bytes_checked,
  output int                   frames_closed
);
  import mrwfb_pkg::*;

  // predictor state
  logic [15:0] crc_run;
  logic [7:0]  data_left;
  logic        in_frame;

  out_item_t expected_bytes[$];
  out_item_t burst[$];
  bit        end_seen;

  // one byte folded into the reflected crc-16
  function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // queue one wire byte of the current burst
  function automatic void emit(input logic [7:0] b, input bit fold, input bit fend);
    out_item_t o;
    o.tx_byte   = b;
    o.frame_end = fend;
    o.run_last  = 1'b0;
    burst.push_back(o);
    if (fold) crc_run = crc16_fold(crc_run, b);
  endfunction

  // one payload byte, then the crc once the count runs out
  function automatic void take_data(input logic [7:0] d);
    logic [15:0] c;
    if (data_left != 0) begin
      emit(d, 1'b1, 1'b0);
      data_left = data_left - 8'd1;
    end
    if (data_left == 0) begin
      c = crc_run;
      emit(c[7:0], 1'b0, 1'b0);
      emit(c[15:8], 1'b0, 1'b1);
      crc_run   = CRC_INIT;
      data_left = 8'd0;
      in_frame  = 1'b0;
    end
  endfunction

  // expected wire bytes caused by one accepted input beat
  function automatic void predict_frame_bytes(input in_item_t it);
    out_item_t o;
    burst.delete();
    if (it.start_frame) begin
      crc_run = CRC_INIT;
      emit(it.slave_addr, 1'b1, 1'b0);
      emit(FUNC_CODE, 1'b1, 1'b0);
      emit(it.reg_addr[15:8], 1'b1, 1'b0);
      emit(it.reg_addr[7:0], 1'b1, 1'b0);
      emit(it.reg_count[15:8], 1'b1, 1'b0);
      emit(it.reg_count[7:0], 1'b1, 1'b0);
      emit(it.byte_count, 1'b1, 1'b0);
      in_frame  = 1'b1;
      data_left = it.byte_count;
      take_data(it.data_byte);
    end else if (in_frame) begin
      take_data(it.data_byte);
    end
    for (int i = 0; i < burst.size(); i++) begin
      o = burst[i];
      o.run_last = (i == burst.size() - 1);
      expected_bytes.push_back(o);
    end
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      crc_run       = CRC_INIT;
      data_left     = 8'd0;
      in_frame      = 1'b0;
      err_count     = 0;
      bytes_checked = 0;
      frames_closed = 0;
      end_seen      = 1'b0;
      expected_bytes.delete();
    end else begin
      if (push && !full) predict_frame_bytes(in_item);
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%02h with nothing expected",
                                    out_item.tx_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte 0x%02h, expected 0x%02h",
                                      out_item.tx_byte, want.tx_byte));
          if (out_item.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, expected %0b",
                                      out_item.frame_end, want.frame_end));
          if (out_item.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, expected %0b",
                                      out_item.run_last, want.run_last));
          bytes_checked++;
          if (want.frame_end) frames_closed++;
        end
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (expected_bytes.size() != 0)
          report_mismatch($sformatf("%0d expected result beats never arrived",
                                    expected_bytes.size()));
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- dv/tb.sv -----
// testbench top of the modbus rtu frame builder: stimulus, idling and verdict
module tb;
  import mrwfb_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 300000;
  localparam int DRAIN_MAX   = 100000;
  localparam int TAIL        = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  logic      empty;
  logic      pop;
  logic      end_check;
  in_item_t  in_item;
  out_item_t out_item;

  int err_count;
  int pending;
  int bytes_checked;
  int frames_closed;
  int send_idle  = 0;
  int recv_idle  = 0;
  int beats_sent = 0;
  int cycle_cnt  = 0;
  bit hold_req   = 1'b0;

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  modbus_rtu_write_frame_builder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  frame_builder_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .empty         (empty),
    .pop           (pop),
    .out_item      (out_item),
    .end_check     (end_check),
    .err_count     (err_count),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  // watchdog
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", LIMIT);
    $display("** modbus_rtu_write_frame_builder_unit: FAILED **");
    $finish;
  end

  // receiver: random pop, plus one long hold counted here
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic in_item_t make_beat(input logic sf, input logic [7:0] sa,
                                         input logic [15:0] ra, input logic [15:0] rc,
                                         input logic [7:0] bc, input logic [7:0] db);
    in_item_t it;
    it.start_frame = sf;
    it.slave_addr  = sa;
    it.reg_addr    = ra;
    it.reg_count   = rc;
    it.byte_count  = bc;
    it.data_byte   = db;
    return it;
  endfunction

  function automatic in_item_t random_beat(input logic sf);
    return make_beat(sf, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                     8'($urandom));
  endfunction

  // offer one beat from a falling edge, return at the falling edge after accept
  task automatic offer_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // start beat and its data beats; a cut frame is left for the next start to abandon
  task automatic send_frame(input logic [7:0] bc, input bit cut);
    in_item_t it;
    int       n_data;
    it = random_beat(1'b1);
    it.byte_count = bc;
    offer_beat(it);
    n_data = (bc == 0) ? 0 : bc - 1;
    if (cut && n_data > 0) n_data = $urandom_range(n_data - 1);
    repeat (n_data) offer_beat(random_beat(1'b0));
  endtask

  // mostly short frames, a few zero, single and mid-length ones
  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'($urandom_range(40, 9));
    if (r < 15) return 8'd0;
    if (r < 25) return 8'd1;
    return 8'($urandom_range(8, 2));
  endfunction

  // well-formed frames with random content, some cut short, some stray data
  task automatic random_phase(input int n);
    int target;
    int r;
    target = beats_sent + n;
    while (beats_sent < target) begin
      r = $urandom_range(99);
      if (r < 10) offer_beat(random_beat(1'b0));
      else if (r < 18) send_frame(8'($urandom_range(8, 2)), 1'b1);
      else send_frame(pick_count(), 1'b0);
    end
  endtask

  // main sequence
  initial begin
    int wait_cnt;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    end_check = 1'b0;
    wait_cnt  = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // sender idles more rarely than the receiver
    send_idle = 34;
    recv_idle = 69;

    // data with no frame open is dropped
    offer_beat(make_beat(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    // zero byte count at both header extremes, data byte ignored
    offer_beat(make_beat(1'b1, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'hFF));
    offer_beat(make_beat(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF));
    // single data byte carried by the start beat
    offer_beat(make_beat(1'b1, 8'h01, 16'h0001, 16'h0001, 8'h01, 8'h00));
    // stray data right after a close
    offer_beat(make_beat(1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00));
    // three byte frame, header fields on data beats are junk
    offer_beat(make_beat(1'b1, 8'h11, 16'h1234, 16'h0002, 8'h03, 8'h80));
    offer_beat(make_beat(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    offer_beat(make_beat(1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h7F));
    // open frame abandoned by a new start
    offer_beat(make_beat(1'b1, 8'h22, 16'hABCD, 16'h0003, 8'h05, 8'h01));
    offer_beat(make_beat(1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h02));
    offer_beat(make_beat(1'b1, 8'h33, 16'h8000, 16'h0001, 8'h02, 8'h55));
    offer_beat(make_beat(1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'hAA));
    // crc starts fresh after the close
    offer_beat(make_beat(1'b1, 8'hF7, 16'h00FF, 16'hFF00, 8'h02, 8'hC3));
    offer_beat(make_beat(1'b0, 8'h5A, 16'h5A5A, 16'hA5A5, 8'h5A, 8'h3C));

    random_phase(45);

    // receiver idles more rarely than the sender
    send_idle = 69;
    recv_idle = 34;
    random_phase(45);

    // no idling; long receiver hold so the block fills and stalls its input
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    random_phase(40);
    // largest count the field allows, abandoned by the next start
    offer_beat(make_beat(1'b1, 8'h5C, 16'hFFFE, 16'h007F, 8'hFF, 8'h01));
    repeat (3) offer_beat(random_beat(1'b0));
    send_frame(8'd2, 1'b0);
    push <= 1'b0;

    // drain, then a quiet tail for stray results
    while (pending != 0 && wait_cnt < DRAIN_MAX) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (TAIL) @(negedge clk);
    end_check <= 1'b1;
    repeat (2) @(negedge clk);

    $display("run covered %0d input beats under three idle mixes and a %0d-cycle receiver hold",
             beats_sent, HOLD_CYCLES);
    $display("%0d result bytes compared, %0d frames closed with crc",
             bytes_checked, frames_closed);
    if (err_count == 0) begin
      $display("** modbus_rtu_write_frame_builder_unit: PASSED **");
    end else begin
      $display("** modbus_rtu_write_frame_builder_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- modbus_rtu_write_frame_builder_unit.f -----
+incdir+rtl
rtl/mrwfb_pkg.sv
rtl/mrwfb_cmdq.sv
rtl/mrwfb_front.sv
rtl/mrwfb_back.sv
rtl/modbus_rtu_write_frame_builder_unit.sv
dv/frame_builder_checker.sv
dv/tb.sv
